### design/lrt_pkg.sv
`timescale 1ns / 1ps

package lrt_pkg;

  // default sizes
  localparam int unsigned DEF_NUM_TABLES  = 8;
  localparam int unsigned DEF_ENTRIES     = 64;
  // table_sel is three bits wide, so at most eight tables can be addressed
  localparam int unsigned SEL_TABLES      = 8;

  // field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TSEL_W  = 3;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IFACE_W = 8;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TIU_W   = 4;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned IN_TUSER_W  = FUNC_W + TSEL_W;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = STAT_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TABLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_LOOK_END,
    S_RESULT
  } lrt_state_e;

  // static part of a route entry
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } route_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              add_write;
    logic              scan;
    logic              clear_valid;
    logic              hit_write;
    logic              load_out;
    logic [STAT_W-1:0] out_status;
    logic              out_hit;
  } lrt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic is_add;
    logic is_del;
    logic full;
    logic empty;
    logic del_match;
    logic cmp_last;
    logic have_best;
    logic out_free;
  } lrt_sts_t;

  // network mask of a prefix length, lengths above 32 act as 32
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= LEN_W'(ADDR_W)) begin
      m = '1;
    end else begin
      m = ~({ADDR_W{1'b1}} >> len[4:0]);
    end
    return m;
  endfunction

endpackage

### design/lrt_ctrl.sv
`timescale 1ns / 1ps

module lrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrt_pkg::lrt_sts_t sts_i,
  output lrt_pkg::lrt_cmd_t cmd_o
);

  lrt_pkg::lrt_state_e state_q, state_d;
  logic [lrt_pkg::STAT_W-1:0] res_q, res_d;
  logic hit_q, hit_d;

  // state and result code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrt_pkg::S_IDLE;
      res_q   <= lrt_pkg::ST_OK;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      hit_q   <= hit_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    hit_d   = hit_q;
    case (state_q)
      lrt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = lrt_pkg::S_DECODE;
          hit_d   = 1'b0;
        end
      end
      lrt_pkg::S_DECODE: begin
        if (sts_i.bad) begin
          state_d = lrt_pkg::S_RESULT;
          res_d   = lrt_pkg::ST_BAD_TABLE;
        end else if (sts_i.is_add) begin
          state_d = lrt_pkg::S_RESULT;
          res_d   = sts_i.full ? lrt_pkg::ST_FULL : lrt_pkg::ST_OK;
        end else if (sts_i.empty) begin
          state_d = lrt_pkg::S_RESULT;
          res_d   = lrt_pkg::ST_MISS;
        end else begin
          state_d = lrt_pkg::S_SCAN;
        end
      end
      lrt_pkg::S_SCAN: begin
        if (sts_i.is_del && sts_i.del_match) begin
          state_d = lrt_pkg::S_RESULT;
          res_d   = lrt_pkg::ST_OK;
        end else if (sts_i.cmp_last) begin
          if (sts_i.is_del) begin
            state_d = lrt_pkg::S_RESULT;
            res_d   = lrt_pkg::ST_MISS;
          end else begin
            state_d = lrt_pkg::S_LOOK_END;
          end
        end
      end
      lrt_pkg::S_LOOK_END: begin
        state_d = lrt_pkg::S_RESULT;
        res_d   = sts_i.have_best ? lrt_pkg::ST_OK : lrt_pkg::ST_MISS;
        hit_d   = sts_i.have_best;
      end
      lrt_pkg::S_RESULT: begin
        if (sts_i.out_free) begin
          state_d = lrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lrt_pkg::S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = res_q;
    cmd_o.out_hit    = hit_q;
    in_ready_o       = 1'b0;
    case (state_q)
      lrt_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lrt_pkg::S_DECODE: begin
        cmd_o.add_write = !sts_i.bad && sts_i.is_add && !sts_i.full;
      end
      lrt_pkg::S_SCAN: begin
        cmd_o.scan        = 1'b1;
        cmd_o.clear_valid = sts_i.is_del && sts_i.del_match;
      end
      lrt_pkg::S_LOOK_END: begin
        cmd_o.hit_write = sts_i.have_best;
      end
      lrt_pkg::S_RESULT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### design/lrt_datapath.sv
`timescale 1ns / 1ps

module lrt_datapath #(
  parameter int unsigned NUM_TABLES        = lrt_pkg::DEF_NUM_TABLES,
  parameter int unsigned ENTRIES_PER_TABLE = lrt_pkg::DEF_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrt_pkg::TIU_W-1:0]       cfg_wdata_i,
  input  logic [lrt_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [lrt_pkg::IN_TUSER_W-1:0]  in_tuser_i,
  output logic                            out_tvalid_o,
  input  logic                            out_tready_i,
  output logic [lrt_pkg::OUT_TDATA_W-1:0] out_tdata_o,
  output logic [lrt_pkg::OUT_TUSER_W-1:0] out_tuser_o,
  input  lrt_pkg::lrt_cmd_t               cmd_i,
  output lrt_pkg::lrt_sts_t               sts_o
);

  // only tables that table_sel can reach get storage
  localparam int unsigned USED_TABLES = (NUM_TABLES < lrt_pkg::SEL_TABLES) ?
                                        NUM_TABLES : lrt_pkg::SEL_TABLES;
  localparam int unsigned SLOTS   = USED_TABLES * ENTRIES_PER_TABLE;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FILL_W  = $clog2(ENTRIES_PER_TABLE + 1);
  localparam int unsigned TIDX_W  = (USED_TABLES > 1) ? $clog2(USED_TABLES) : 1;

  // captured item
  logic [lrt_pkg::FUNC_W-1:0]  func_q;
  logic [lrt_pkg::TSEL_W-1:0]  tsel_q;
  logic [lrt_pkg::ADDR_W-1:0]  paddr_q, daddr_q, hop_q;
  logic [lrt_pkg::LEN_W-1:0]   plen_q;
  logic [lrt_pkg::IFACE_W-1:0] iface_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_tuser_i[1:0];
      tsel_q  <= in_tuser_i[4:2];
      paddr_q <= in_tdata_i[31:0];
      plen_q  <= in_tdata_i[37:32];
      daddr_q <= in_tdata_i[69:38];
      hop_q   <= in_tdata_i[101:70];
      iface_q <= in_tdata_i[109:102];
    end
  end

  // tables in use register
  logic [lrt_pkg::TIU_W-1:0] tiu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiu_q <= lrt_pkg::TIU_W'(1);
    end else if (cfg_we_i) begin
      tiu_q <= cfg_wdata_i;
    end
  end

  // decode of the captured item
  logic              bad, is_add, is_del, is_lookup;
  logic [TIDX_W-1:0] tidx;

  assign is_add    = (func_q == lrt_pkg::FUNC_ADD);
  assign is_del    = (func_q == lrt_pkg::FUNC_DEL);
  assign is_lookup = (func_q == lrt_pkg::FUNC_LOOKUP);
  assign bad       = !(is_add || is_del || is_lookup)
                   || ({1'b0, tsel_q} >= tiu_q)
                   || ({1'b0, tsel_q} >= lrt_pkg::TIU_W'(USED_TABLES));
  assign tidx      = TIDX_W'(tsel_q);

  // per table fill counts
  logic [FILL_W-1:0] fill_q [USED_TABLES];
  logic [FILL_W-1:0] n;

  assign n = fill_q[tidx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < int'(USED_TABLES); t++) begin
        fill_q[t] <= '0;
      end
    end else if (cmd_i.add_write) begin
      fill_q[tidx] <= n + FILL_W'(1);
    end
  end

  // slot addresses
  logic [SLOT_W-1:0] base, wr_slot, rd_slot, cmp_slot;
  logic [FILL_W-1:0] rd_idx_q, cmp_idx_q;
  logic              rd_en, rdv_q;

  assign base     = SLOT_W'(32'(tsel_q) * ENTRIES_PER_TABLE);
  assign wr_slot  = base + SLOT_W'(n);
  assign rd_slot  = base + SLOT_W'(rd_idx_q);
  assign cmp_slot = base + SLOT_W'(cmp_idx_q);
  assign rd_en    = cmd_i.scan && (rd_idx_q < n);

  // scan read counter and read data tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      rdv_q     <= 1'b0;
    end else if (cmd_i.capture) begin
      rd_idx_q <= '0;
      rdv_q    <= 1'b0;
    end else begin
      rdv_q <= rd_en;
      if (rd_en) begin
        rd_idx_q  <= rd_idx_q + FILL_W'(1);
        cmp_idx_q <= rd_idx_q;
      end
    end
  end

  // route memory, written by add only
  lrt_pkg::route_t route_mem [SLOTS];
  lrt_pkg::route_t route_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      route_mem[wr_slot] <= '{addr: paddr_q, len: plen_q, hop: hop_q, iface: iface_q};
    end
    if (rd_en) begin
      route_rd_q <= route_mem[rd_slot];
    end
  end

  // valid memory, set by add and cleared by delete
  logic              valid_mem [SLOTS];
  logic              valid_rd_q;
  logic              valid_we, valid_wd;
  logic [SLOT_W-1:0] valid_wa;

  assign valid_we = cmd_i.add_write || cmd_i.clear_valid;
  assign valid_wd = cmd_i.add_write;
  assign valid_wa = cmd_i.clear_valid ? cmp_slot : wr_slot;

  always_ff @(posedge clk_i) begin
    if (valid_we) begin
      valid_mem[valid_wa] <= valid_wd;
    end
    if (rd_en) begin
      valid_rd_q <= valid_mem[rd_slot];
    end
  end

  // hit counter memory, zeroed by add and bumped by a lookup hit
  logic [lrt_pkg::HITS_W-1:0] hits_mem [SLOTS];
  logic [lrt_pkg::HITS_W-1:0] hits_rd_q, hits_wd, best_hits_q, hits_inc;
  logic [SLOT_W-1:0]          hits_wa, best_slot_q;
  logic                       hits_we;

  assign hits_inc = best_hits_q + lrt_pkg::HITS_W'(1);
  assign hits_we  = cmd_i.add_write || cmd_i.hit_write;
  assign hits_wa  = cmd_i.hit_write ? best_slot_q : wr_slot;
  assign hits_wd  = cmd_i.hit_write ? hits_inc : '0;

  always_ff @(posedge clk_i) begin
    if (hits_we) begin
      hits_mem[hits_wa] <= hits_wd;
    end
    if (rd_en) begin
      hits_rd_q <= hits_mem[rd_slot];
    end
  end

  // compare of the entry read in the previous cycle
  logic [lrt_pkg::ADDR_W-1:0] mask;
  logic                       del_match, look_match;

  assign mask       = lrt_pkg::len_mask(route_rd_q.len);
  assign del_match  = rdv_q && valid_rd_q && (route_rd_q.addr == paddr_q)
                    && (route_rd_q.len == plen_q);
  assign look_match = rdv_q && valid_rd_q
                    && ((daddr_q & mask) == (route_rd_q.addr & mask));

  // best match so far, later entries win ties
  logic                        have_q;
  logic [lrt_pkg::LEN_W-1:0]   best_len_q;
  logic [lrt_pkg::ADDR_W-1:0]  best_hop_q;
  logic [lrt_pkg::IFACE_W-1:0] best_iface_q;
  logic                        take;

  assign take = cmd_i.scan && is_lookup && look_match && (route_rd_q.len >= best_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      best_len_q <= '0;
    end else if (cmd_i.capture) begin
      have_q     <= 1'b0;
      best_len_q <= '0;
    end else if (take) begin
      have_q     <= 1'b1;
      best_len_q <= route_rd_q.len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_slot_q  <= cmp_slot;
      best_hop_q   <= route_rd_q.hop;
      best_iface_q <= route_rd_q.iface;
      best_hits_q  <= hits_rd_q;
    end else if (cmd_i.hit_write) begin
      best_hits_q <= hits_inc;
    end
  end

  // output register
  logic                        out_valid_q;
  logic [lrt_pkg::STAT_W-1:0]  out_status_q;
  logic [lrt_pkg::ADDR_W-1:0]  out_hop_q;
  logic [lrt_pkg::IFACE_W-1:0] out_iface_q;
  logic [lrt_pkg::HITS_W-1:0]  out_hits_q;
  logic                        out_free;

  assign out_free = !out_valid_q || out_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_hop_q    <= cmd_i.out_hit ? best_hop_q : '0;
      out_iface_q  <= cmd_i.out_hit ? best_iface_q : '0;
      out_hits_q   <= cmd_i.out_hit ? best_hits_q : '0;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {out_hits_q, out_iface_q, out_hop_q};
  assign out_tuser_o  = out_status_q;

  // status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.bad       = bad;
    sts_o.is_add    = is_add;
    sts_o.is_del    = is_del;
    sts_o.full      = (n == FILL_W'(ENTRIES_PER_TABLE));
    sts_o.empty     = (n == '0);
    sts_o.del_match = del_match;
    sts_o.cmp_last  = rdv_q && ((cmp_idx_q + FILL_W'(1)) == n);
    sts_o.have_best = have_q;
    sts_o.out_free  = out_free;
  end

`ifndef SYNTHESIS
  // an append never lands in a full or rejected table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_write |-> (!bad && (n != FILL_W'(ENTRIES_PER_TABLE))))
    else $error("append into full or rejected table");

  // a delete only clears an entry that compared equal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_valid |-> (del_match && is_del))
    else $error("entry cleared without a match");

  // the hit counter is bumped only after a match was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hit_write |-> (have_q && is_lookup))
    else $error("hit write without a best match");

  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tready_i) |-> !cmd_i.load_out)
    else $error("result overwritten while stalled");
`endif

endmodule

### design/lpm_route_table.sv
`timescale 1ns / 1ps
// sequence: an item is captured, then decoded; an add, a rejected item or an item for an empty
// table goes straight to the result, a lookup scans the table and then writes back the hit
// count, and a delete scans until an entry matches or the last entry has been compared
// throughput: one item at a time, the result waits for a free output register, and the scan
// reads one entry per cycle through the entry memory read port
// reset: asynchronous active low, clears fill counts and control state, tables in use is 1
module lpm_route_table #(
  parameter int unsigned NUM_TABLES        = lrt_pkg::DEF_NUM_TABLES,
  parameter int unsigned ENTRIES_PER_TABLE = lrt_pkg::DEF_ENTRIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // register write: tables_in_use
  input  logic                            cfg_we_i,
  input  logic [lrt_pkg::TIU_W-1:0]       cfg_wdata_i,
  // request items
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // prefix_addr[31:0], pfx_len[37:32], dest_addr[69:38], hop_addr[101:70],
  // iface_in[109:102], zero fill[111:110]
  input  logic [lrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // func[1:0], table_sel[4:2]
  input  logic [lrt_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  // result items
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // found_hop[31:0], found_iface[39:32], hits_now[71:40]
  output logic [lrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [lrt_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  lrt_pkg::lrt_cmd_t cmd;
  lrt_pkg::lrt_sts_t sts;

  // sequencer
  lrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, compare logic and result register
  lrt_datapath #(
    .NUM_TABLES        (NUM_TABLES),
    .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .out_tvalid_o (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_o  (m_axis_tdata_o),
    .out_tuser_o  (m_axis_tuser_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lrt_pkg::*;

  localparam int unsigned NUM_T       = DEF_NUM_TABLES;
  localparam int unsigned ENTRIES     = DEF_ENTRIES;
  localparam int unsigned SLOTS       = NUM_T * ENTRIES;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 20000;
  // the fourth operation code has no meaning and is rejected
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TIU_W-1:0]  TIU_NONE    = 4'd0;
  localparam logic [TIU_W-1:0]  TIU_ONE     = 4'd1;
  localparam logic [TIU_W-1:0]  TIU_THREE   = 4'd3;
  localparam logic [TIU_W-1:0]  TIU_ALL     = 4'd8;
  localparam logic [TIU_W-1:0]  TIU_MAX     = 4'd15;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [TSEL_W-1:0]  tsel;
    logic [ADDR_W-1:0]  paddr;
    logic [LEN_W-1:0]   plen;
    logic [ADDR_W-1:0]  daddr;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } route_req_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
    logic [HITS_W-1:0]  hits;
  } route_reply_t;

  // route table mirror plus the queue of replies it predicts
  class route_checker;
    logic [ADDR_W-1:0]  slot_addr  [SLOTS];
    logic [LEN_W-1:0]   slot_len   [SLOTS];
    logic [ADDR_W-1:0]  slot_hop   [SLOTS];
    logic [IFACE_W-1:0] slot_iface [SLOTS];
    bit                 slot_valid [SLOTS];
    logic [HITS_W-1:0]  slot_hits  [SLOTS];
    int unsigned        fill       [NUM_T];
    logic [TIU_W-1:0]   tables_in_use;
    route_reply_t       expected_replies[$];
    int                 errors;

    function new();
      tables_in_use = TIU_ONE;
      errors = 0;
      foreach (fill[i]) fill[i] = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      if (len >= ADDR_W) return '1;
      return ~(32'hFFFF_FFFF >> len);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // update the mirror for one accepted request and queue its reply
    function void apply_request(input route_req_t r);
      route_reply_t      e;
      int unsigned       base;
      int unsigned       n;
      int unsigned       best;
      logic [LEN_W-1:0]  best_len;
      logic [ADDR_W-1:0] m;
      bit                have;
      e.status = ST_BAD_TABLE;
      e.hop    = '0;
      e.iface  = '0;
      e.hits   = '0;
      if (r.func != FUNC_UNUSED && {1'b0, r.tsel} < tables_in_use) begin
        base = r.tsel * ENTRIES;
        n = fill[r.tsel];
        case (r.func)
          FUNC_ADD: begin
            if (n >= ENTRIES) begin
              e.status = ST_FULL;
            end else begin
              slot_addr[base + n]  = r.paddr;
              slot_len[base + n]   = r.plen;
              slot_hop[base + n]   = r.hop;
              slot_iface[base + n] = r.iface;
              slot_valid[base + n] = 1'b1;
              slot_hits[base + n]  = '0;
              fill[r.tsel] = n + 1;
              e.status = ST_OK;
            end
          end
          FUNC_DEL: begin
            e.status = ST_MISS;
            for (int unsigned i = 0; i < n; i++) begin
              if (slot_valid[base + i] && slot_addr[base + i] == r.paddr &&
                  slot_len[base + i] == r.plen) begin
                slot_valid[base + i] = 1'b0;
                e.status = ST_OK;
                break;
              end
            end
          end
          default: begin
            // longest prefix wins, later entry on equal length
            have = 1'b0;
            best = 0;
            best_len = '0;
            for (int unsigned i = 0; i < n; i++) begin
              if (slot_valid[base + i]) begin
                m = prefix_mask(slot_len[base + i]);
                if ((r.daddr & m) == (slot_addr[base + i] & m) &&
                    slot_len[base + i] >= best_len) begin
                  best_len = slot_len[base + i];
                  best = base + i;
                  have = 1'b1;
                end
              end
            end
            if (have) begin
              slot_hits[best] = slot_hits[best] + 1'b1;
              e.status = ST_OK;
              e.hop    = slot_hop[best];
              e.iface  = slot_iface[best];
              e.hits   = slot_hits[best];
            end else begin
              e.status = ST_MISS;
            end
          end
        endcase
      end
      expected_replies.push_back(e);
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted reply with the oldest prediction
    task check_reply(input logic [STAT_W-1:0] status, input logic [ADDR_W-1:0] hop,
                     input logic [IFACE_W-1:0] iface, input logic [HITS_W-1:0] hits);
      route_reply_t e;
      if (expected_replies.size() == 0) begin
        report("reply arrived with none outstanding");
        return;
      end
      e = expected_replies.pop_front();
      if (status !== e.status)
        report($sformatf("status got %0d want %0d", status, e.status));
      if (hop !== e.hop)
        report($sformatf("found_hop got %h want %h", hop, e.hop));
      if (iface !== e.iface)
        report($sformatf("found_iface got %h want %h", iface, e.iface));
      if (hits !== e.hits)
        report($sformatf("hits_now got %0d want %0d", hits, e.hits));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [TIU_W-1:0]       cfg_wdata = '0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;

  int send_idle_pct = 28;
  int recv_idle_pct = 64;
  int stall_asked = 0;
  int stall_given = 0;
  int stall_left = 0;

  route_checker sb;

  lpm_route_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side readiness, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (stall_asked != stall_given) begin
      stall_given++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // check every accepted result item
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready)
      sb.check_reply(m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[71:40]);
  end

  // offer one request item and wait for it to be taken
  task automatic send_item(input route_req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {2'b00, r.iface, r.hop, r.daddr, r.plen, r.paddr};
    s_tuser <= {r.tsel, r.func};
    do @(posedge clk_i); while (!s_ready);
    sb.apply_request(r);
  endtask

  task automatic issue(input logic [FUNC_W-1:0] func, input logic [TSEL_W-1:0] tsel,
                       input logic [ADDR_W-1:0] paddr, input logic [LEN_W-1:0] plen,
                       input logic [ADDR_W-1:0] daddr, input logic [ADDR_W-1:0] hop,
                       input logic [IFACE_W-1:0] iface);
    route_req_t r;
    r.func  = func;
    r.tsel  = tsel;
    r.paddr = paddr;
    r.plen  = plen;
    r.daddr = daddr;
    r.hop   = hop;
    r.iface = iface;
    send_item(r);
  endtask

  // let all outstanding replies drain, then write the table count
  task automatic set_tables(input logic [TIU_W-1:0] v);
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.tables_in_use = v;
  endtask

  // random request, deletes and lookups often aimed at prefixes already in the table
  task automatic make_random(output route_req_t r);
    int                kind;
    int unsigned       n;
    int unsigned       slot;
    logic [ADDR_W-1:0] m;
    kind    = $urandom_range(0, 99);
    r.tsel  = $urandom_range(0, 1) ? '0 : TSEL_W'($urandom_range(0, NUM_T - 1));
    r.paddr = $urandom;
    r.plen  = LEN_W'($urandom_range(0, 63));
    r.daddr = $urandom;
    r.hop   = $urandom;
    r.iface = IFACE_W'($urandom_range(0, 255));
    n = sb.fill[r.tsel];
    slot = r.tsel * ENTRIES + ((n > 0) ? $urandom_range(0, n - 1) : 0);
    if (kind < 3) begin
      r.func = FUNC_UNUSED;
    end else if (kind < 38) begin
      r.func = FUNC_ADD;
      r.paddr[31:24] = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) r.plen = LEN_W'($urandom_range(0, 32));
    end else if (kind < 55) begin
      r.func = FUNC_DEL;
      if (n > 0 && $urandom_range(0, 99) < 80) begin
        r.paddr = sb.slot_addr[slot];
        r.plen  = sb.slot_len[slot];
      end
    end else begin
      r.func = FUNC_LOOKUP;
      if (n > 0 && $urandom_range(0, 99) < 70) begin
        m = sb.prefix_mask(sb.slot_len[slot]);
        r.daddr = (sb.slot_addr[slot] & m) | ($urandom & ~m);
      end else if ($urandom_range(0, 1) == 1) begin
        r.daddr[31:24] = 8'($urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    route_req_t       r;
    int               count;
    int               guard;
    logic [TIU_W-1:0] phase_tiu [6];
    int               phase_len [6];
    phase_tiu = '{TIU_ALL, TIU_THREE, TIU_MAX, TIU_NONE, TIU_ONE, TIU_ALL};
    phase_len = '{230, 150, 150, 20, 100, 100};
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, default route, host route, long prefix, ties and deletes
    issue(FUNC_LOOKUP, 0, '0, 0, '0, '0, '0);
    issue(FUNC_DEL, 0, '0, 0, '0, '0, '0);
    issue(FUNC_ADD, 0, '0, 0, '0, '0, '0);
    issue(FUNC_ADD, 0, '1, 32, '0, '1, '1);
    issue(FUNC_ADD, 0, 32'h0A00_0000, 8, '0, 32'h0A00_00FE, 8'd1);
    issue(FUNC_ADD, 0, 32'hC0A8_0101, 63, '0, 32'hC0A8_01FE, 8'd2);
    issue(FUNC_LOOKUP, 0, '0, 0, '1, '0, '0);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'hC0A8_0101, '0, '0);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'h0A01_0203, '0, '0);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'h1234_5678, '0, '0);
    issue(FUNC_ADD, 0, 32'h0A00_0000, 8, '0, 32'h0A00_00FD, 8'd3);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'h0A09_0909, '0, '0);
    issue(FUNC_DEL, 0, 32'h0A00_0000, 8, '0, '0, '0);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'h0A09_0909, '0, '0);
    issue(FUNC_DEL, 0, 32'h0A00_0000, 8, '0, '0, '0);
    issue(FUNC_DEL, 0, 32'h0A00_0000, 8, '0, '0, '0);
    issue(FUNC_LOOKUP, 0, '0, 0, 32'h0A09_0909, '0, '0);
    issue(FUNC_UNUSED, 0, '1, 63, '1, '1, '1);
    issue(FUNC_ADD, 1, 32'h0100_0000, 8, '0, '0, '0);
    issue(FUNC_LOOKUP, 7, '0, 0, '0, '0, '0);
    // no tables enabled, then a count above the table total
    set_tables(TIU_NONE);
    issue(FUNC_LOOKUP, 0, '0, 0, '0, '0, '0);
    issue(FUNC_ADD, 0, '0, 0, '0, '0, '0);
    set_tables(TIU_MAX);
    issue(FUNC_LOOKUP, 7, '0, 0, '0, '0, '0);
    issue(FUNC_ADD, 7, 32'h0200_0000, 7, '0, 32'h0200_0001, 8'd7);
    issue(FUNC_LOOKUP, 7, '0, 0, 32'h0300_0000, '0, '0);

    // random phases over several table counts
    count = 0;
    for (int p = 0; p < 6; p++) begin
      set_tables(phase_tiu[p]);
      for (int k = 0; k < phase_len[p]; k++) begin
        if (count == 250) begin
          send_idle_pct = 64;
          recv_idle_pct = 28;
        end
        if (count == 500) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (count == 100 || count == 520) stall_asked++;
        make_random(r);
        send_item(r);
        count++;
      end
    end

    // drain and finish
    @(negedge clk_i);
    s_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("replies still outstanding at end of run");
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #10000000;
    $display("tb: errors");
    $finish;
  end

endmodule
